/* hdl/cpr_pkg.sv */
package cpr_pkg;

    // frames_in_use register width
    localparam int CFG_W = 6;
    // fault counter width
    localparam int CNT_W = 32;

    // per-cycle command broadcast from the controller to every cell
    typedef struct packed {
        logic clear_all;  // empty the ring (valid and use bits)
        logic inject;     // drop the token into the cell named by the index
        logic kill;       // remove the token
        logic advance;    // token moves one cell on
        logic wrap;       // token moves from the last ring cell back to cell 0
        logic search;     // token cell checks for a hit
        logic sweep;      // token cell clears its use bit or takes the page
    } t_cell_cmd;

    // what the token-holding cell reports
    typedef struct packed {
        logic match;
        logic use_set;
        logic valid;
    } t_cell_stat;

endpackage

/* hdl/cpr_cell.sv */
module cpr_cell #(
    parameter int CELL_ID   = 0,
    parameter int IDX_W     = 5,
    parameter int PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpr_pkg::t_cell_cmd   i_cmd,
    input  logic [IDX_W-1:0]     i_inj_idx,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic                 i_tok_prev,
    output logic                 o_tok,
    output cpr_pkg::t_cell_stat  o_stat,
    output logic [PAGE_BITS-1:0] o_page
);
    import cpr_pkg::*;

    logic                 r_tok;
    logic                 r_valid;
    logic                 r_use;
    logic [PAGE_BITS-1:0] r_page;
    logic                 w_match;

    assign w_match = r_tok & r_valid & (r_page == i_page);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_valid <= 1'b0;
            r_use   <= 1'b0;
        end else begin
            priority if (i_cmd.inject) begin
                r_tok <= (i_inj_idx == IDX_W'(CELL_ID));
            end else if (i_cmd.kill || i_cmd.clear_all) begin
                r_tok <= 1'b0;
            end else if (i_cmd.advance) begin
                r_tok <= i_cmd.wrap ? (CELL_ID == 0) : i_tok_prev;
            end else begin
                r_tok <= r_tok;
            end

            priority if (i_cmd.clear_all) begin
                r_valid <= 1'b0;
                r_use   <= 1'b0;
            end else if (i_cmd.search && w_match) begin
                r_use <= 1'b1;
            end else if (i_cmd.sweep && r_tok) begin
                if (r_use) begin
                    r_use <= 1'b0;          // second chance used up
                end else begin
                    r_valid <= 1'b1;
                    r_use   <= 1'b1;
                end
            end else begin
                r_use <= r_use;
            end
        end
    end

    // page is payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep && r_tok && !r_use && !i_cmd.clear_all) begin
            r_page <= i_page;
        end
    end

    assign o_tok          = r_tok;
    assign o_stat.match   = w_match;
    assign o_stat.use_set = r_tok & r_use;
    assign o_stat.valid   = r_tok & r_valid;
    // an empty frame reports page zero
    assign o_page         = (r_tok & r_valid) ? r_page : '0;

endmodule

/* hdl/cpr_chain.sv */
module cpr_chain #(
    parameter int FRAMES    = 32,
    parameter int IDX_W     = 5,
    parameter int PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpr_pkg::t_cell_cmd   i_cmd,
    input  logic [IDX_W-1:0]     i_inj_idx,
    input  logic [PAGE_BITS-1:0] i_page,
    output cpr_pkg::t_cell_stat  o_stat,
    output logic [PAGE_BITS-1:0] o_page
);
    import cpr_pkg::*;

    logic [FRAMES-1:0]    w_tok;
    logic [FRAMES-1:0]    w_tok_prev;
    t_cell_stat           w_stat [FRAMES];
    logic [PAGE_BITS-1:0] w_page [FRAMES];

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_tok_prev[g] = 1'b0;
        end else begin : g_body
            assign w_tok_prev[g] = w_tok[g-1];
        end

        cpr_cell #(
            .CELL_ID   (g),
            .IDX_W     (IDX_W),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (i_cmd),
            .i_inj_idx  (i_inj_idx),
            .i_page     (i_page),
            .i_tok_prev (w_tok_prev[g]),
            .o_tok      (w_tok[g]),
            .o_stat     (w_stat[g]),
            .o_page     (w_page[g])
        );
    end

    // only the token cell drives non-zero, so a plain OR collects it
    always_comb begin
        o_stat = '0;
        o_page = '0;
        for (int k = 0; k < FRAMES; k++) begin
            o_stat = o_stat | w_stat[k];
            o_page = o_page | w_page[k];
        end
    end

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one cell holds the token");

endmodule

/* hdl/clock_page_replacement_unit.sv */
// Clock (second chance) page replacement, one reference per word.
// A hit ends the search at the frame holding the page; a fault searches the whole ring
// and then sweeps from the hand until a frame with a clear use bit is found.
// One word at a time: the next word is accepted in the cycle after its result is made;
// search and sweep walk the token along the chain and stall while the output is held.
// Reset (synchronous, i_rst_n low): ring empty, hand 0, fault count 0, ring = FRAMES.
module clock_page_replacement_unit #(
    parameter int  FRAMES    = 32,
    parameter int  PAGE_BITS = 16,
    localparam int IDX_W     = $clog2(FRAMES),
    localparam int IN_W      = ((PAGE_BITS + 7) / 8) * 8,
    localparam int OUT_RAW   = 2 + IDX_W + PAGE_BITS + cpr_pkg::CNT_W,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0] i_cfg_wdata,  // frames_in_use
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_W-1:0]          s_tdata,      // page_number
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // hit, frame_index, victim_valid, victim_page, fault_count (lowest first)
    output logic [OUT_W-1:0]         m_tdata
);
    import cpr_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_SWEEP} t_state;

    t_state               r_state;
    logic [IDX_W-1:0]     r_pos;    // cell holding the token
    logic [IDX_W-1:0]     r_hand;
    logic [IDX_W-1:0]     r_last;   // ring size minus one
    logic [CNT_W-1:0]     r_faults;
    logic [PAGE_BITS-1:0] r_page;   // page of the word in flight

    // output register
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [IDX_W-1:0]     r_out_idx;
    logic                 r_out_vv;
    logic [PAGE_BITS-1:0] r_out_vpage;
    logic [CNT_W-1:0]     r_out_faults;

    t_cell_cmd            w_cmd;
    logic [IDX_W-1:0]     w_inj_idx;
    t_cell_stat           w_stat;
    logic [PAGE_BITS-1:0] w_vpage;
    logic                 w_go;     // room for a result
    logic                 w_accept;
    logic                 w_done;   // result word produced this cycle
    logic                 w_at_last;
    logic [IDX_W-1:0]     w_pos_next;
    logic [CNT_W-1:0]     w_faults_inc;

    assign s_tready     = (r_state == ST_IDLE);
    assign w_accept     = s_tvalid & s_tready;
    assign w_go         = ~r_out_valid | m_tready;
    assign w_done       = w_go & (((r_state == ST_SEARCH) & w_stat.match)
                                | ((r_state == ST_SWEEP) & ~w_stat.use_set));
    assign w_at_last    = (r_pos == r_last);
    assign w_pos_next   = w_at_last ? '0 : IDX_W'(r_pos + 1'b1);
    assign w_faults_inc = (r_faults == '1) ? r_faults : r_faults + 1'b1;

    // commands to the chain
    always_comb begin
        w_cmd     = '0;
        w_inj_idx = '0;
        unique case (r_state)
            ST_IDLE: begin
                w_cmd.clear_all = i_cfg_we;
                w_cmd.inject    = w_accept;  // search starts at frame 0
            end
            ST_SEARCH: begin
                if (w_go) begin
                    w_cmd.search = 1'b1;
                    priority if (w_stat.match) begin
                        w_cmd.kill = 1'b1;
                    end else if (w_at_last) begin
                        w_cmd.inject = 1'b1;  // miss: sweep starts at the hand
                        w_inj_idx    = r_hand;
                    end else begin
                        w_cmd.advance = 1'b1;
                    end
                end
            end
            ST_SWEEP: begin
                if (w_go) begin
                    w_cmd.sweep = 1'b1;
                    if (w_stat.use_set) begin
                        w_cmd.advance = 1'b1;
                        w_cmd.wrap    = w_at_last;
                    end else begin
                        w_cmd.kill = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    cpr_chain #(
        .FRAMES    (FRAMES),
        .IDX_W     (IDX_W),
        .PAGE_BITS (PAGE_BITS)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_inj_idx (w_inj_idx),
        .i_page    (r_page),
        .o_stat    (w_stat),
        .o_page    (w_vpage)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_hand      <= '0;
            r_last      <= IDX_W'(FRAMES - 1);
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cfg_we) begin
                        // ring size clamped to 1..FRAMES, ring emptied
                        r_hand <= '0;
                        priority if (i_cfg_wdata == '0) begin
                            r_last <= '0;
                        end else if (32'(i_cfg_wdata) > 32'(FRAMES)) begin
                            r_last <= IDX_W'(FRAMES - 1);
                        end else begin
                            r_last <= IDX_W'(i_cfg_wdata - CFG_W'(1));
                        end
                    end
                    if (w_accept) begin
                        r_page  <= s_tdata[PAGE_BITS-1:0];
                        r_pos   <= '0;
                        r_state <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (w_go) begin
                        priority if (w_stat.match) begin
                            r_out_hit    <= 1'b1;
                            r_out_idx    <= r_pos;
                            r_out_vv     <= 1'b0;
                            r_out_vpage  <= '0;
                            r_out_faults <= r_faults;
                            r_state      <= ST_IDLE;
                        end else if (w_at_last) begin
                            r_pos   <= r_hand;
                            r_state <= ST_SWEEP;
                        end else begin
                            r_pos <= w_pos_next;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (w_go) begin
                        if (w_stat.use_set) begin
                            r_pos <= w_pos_next;
                        end else begin
                            // frame taken: report victim, hand one on
                            r_out_hit    <= 1'b0;
                            r_out_idx    <= r_pos;
                            r_out_vv     <= w_stat.valid;
                            r_out_vpage  <= w_vpage;
                            r_out_faults <= w_faults_inc;
                            r_faults     <= w_faults_inc;
                            r_hand       <= w_pos_next;
                            r_state      <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = OUT_W'({r_out_faults, r_out_vpage, r_out_vv, r_out_idx, r_out_hit});

    a_hand_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hand <= r_last))
        else $error("hand outside the ring");

    a_pos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_pos <= r_last))
        else $error("token position outside the ring");

    a_hit_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_hit) |-> (!r_out_vv && r_out_vpage == '0))
        else $error("victim reported on a hit");

    a_faults_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_faults >= $past(r_faults)))
        else $error("fault count went down");

endmodule

/* verif/clock_page_replacement_unit_tb.sv */
`timescale 1ns / 1ps

module clock_page_replacement_unit_tb;
    import cpr_pkg::*;

    localparam int FRAMES    = 32;
    localparam int PAGE_BITS = 16;
    localparam int IDX_W     = $clog2(FRAMES);
    localparam int IN_W      = ((PAGE_BITS + 7) / 8) * 8;
    localparam int OUT_RAW   = 2 + IDX_W + PAGE_BITS + CNT_W;
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8;

    // result word, lowest field in bit 0
    typedef struct packed {
        logic [CNT_W-1:0]     fault_count;
        logic [PAGE_BITS-1:0] victim_page;
        logic                 victim_valid;
        logic [IDX_W-1:0]     frame_index;
        logic                 hit;
    } page_result_t;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata     = '0;   // page_number
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [OUT_W-1:0]  m_tdata;            // hit, frame_index, victim_valid, victim_page,
                                           // fault_count (lowest first)

    clock_page_replacement_unit #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5;
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Our own copy of the ring: pages, valid marks, use bits, hand, count
    // ------------------------------------------------------------------
    logic [PAGE_BITS-1:0] ring_page  [FRAMES];
    logic                 ring_valid [FRAMES];
    logic                 ring_use   [FRAMES];
    logic [IDX_W-1:0]     ring_hand;
    logic [CNT_W-1:0]     ring_faults;
    logic [CFG_W-1:0]     ring_cfg;

    page_result_t expected_results[$];
    int error_count = 0;

    // sender burst state
    int burst_left = 0;

    // receiver stall pattern
    int       mode_left  = 0;
    int       stall_left = 0;
    int       ready_mode = 0;

    function automatic void empty_ring();
        for (int f = 0; f < FRAMES; f++) begin
            ring_valid[f] = 1'b0;
            ring_use[f]   = 1'b0;
            ring_page[f]  = '0;
        end
        ring_hand = '0;
    endfunction

    // One reference through the clock scheme; updates the copy, returns the word.
    function automatic page_result_t resolve_reference(input logic [PAGE_BITS-1:0] page);
        page_result_t res;
        int n;
        int h;
        int slot;
        logic found;
        n = int'(ring_cfg);
        if (n == 0) n = 1;
        if (n > FRAMES) n = FRAMES;
        h = int'(ring_hand);
        if (h >= n) h = 0;
        found = 1'b0;
        slot  = 0;
        res   = '0;
        // lowest matching valid frame wins
        for (int f = 0; f < n; f++) begin
            if (!found && ring_valid[f] && ring_page[f] == page) begin
                found = 1'b1;
                slot  = f;
            end
        end
        if (found) begin
            ring_use[slot] = 1'b1;
        end else begin
            // second chance: clear set use bits until a clear one is reached
            while (ring_use[h]) begin
                ring_use[h] = 1'b0;
                h = (h + 1 >= n) ? 0 : h + 1;
            end
            slot = h;
            if (ring_valid[slot]) begin
                res.victim_valid = 1'b1;
                res.victim_page  = ring_page[slot];
            end
            ring_page[slot]  = page;
            ring_valid[slot] = 1'b1;
            ring_use[slot]   = 1'b1;
            h = (h + 1 >= n) ? 0 : h + 1;
            if (ring_faults != '1) ring_faults = ring_faults + 1'b1;
        end
        ring_hand       = IDX_W'(h);
        res.hit         = found;
        res.frame_index = IDX_W'(slot);
        res.fault_count = ring_faults;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall pattern picks a new random mode whenever its mode counter runs out
    // mode 0 always ready, mode 1 random drops, mode 2 long stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            case (ready_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 40);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        page_result_t got;
        page_result_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = page_result_t'(m_tdata[OUT_RAW-1:0]);
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: %h", m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit expected %0d actual %0d", want.hit, got.hit);
                    error_count++;
                end
                if (got.frame_index !== want.frame_index) begin
                    $error("frame_index expected %0d actual %0d",
                           want.frame_index, got.frame_index);
                    error_count++;
                end
                if (got.victim_valid !== want.victim_valid) begin
                    $error("victim_valid expected %0d actual %0d",
                           want.victim_valid, got.victim_valid);
                    error_count++;
                end
                if (got.victim_page !== want.victim_page) begin
                    $error("victim_page expected %h actual %h",
                           want.victim_page, got.victim_page);
                    error_count++;
                end
                if (got.fault_count !== want.fault_count) begin
                    $error("fault_count expected %0d actual %0d",
                           want.fault_count, got.fault_count);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: one reference word, bursts of random length, random gaps
    // ------------------------------------------------------------------
    task automatic send_page(input logic [PAGE_BITS-1:0] page);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(page);
        do @(posedge i_clk); while (!s_tready);
        expected_results.insert(expected_results.size(), resolve_reference(page));
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // drop valid and wait for every outstanding word to come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        // no word is in flight once the queue is empty; a short settle anyway
        repeat (4) @(posedge i_clk);
    endtask

    // ring size write, only with the block idle
    task automatic write_frames_in_use(input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ring_cfg = value;
        empty_ring();       // a write empties the ring, fault count kept
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // default ring after reset: page field extremes, miss then hit
    task automatic test_reset_ring();
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'hFFFF);
    endtask

    // ring sizes zero and one act as one frame: each new page after the first evicts the last
    task automatic test_single_frame();
        write_frames_in_use(CFG_W'(0));
        send_page(16'h1234);
        send_page(16'h1234);
        send_page(16'hABCD);
        write_frames_in_use(CFG_W'(1));
        send_page(16'h5A5A);
        send_page(16'hA5A5);
    endtask

    // three frames: fill, hit, then a full sweep clearing every use bit
    task automatic test_second_chance();
        write_frames_in_use(CFG_W'(3));
        send_page(16'h0011);
        send_page(16'h0022);
        send_page(16'h0033);
        send_page(16'h0011);
        send_page(16'h0044);
        send_page(16'h0022);
        send_page(16'h0033);
    endtask

    // values above the frame count act as the full ring
    task automatic test_oversized_ring();
        write_frames_in_use(CFG_W'(63));
        send_page(16'h8000);
        send_page(16'h0001);
        send_page(16'h8000);
        write_frames_in_use(CFG_W'(33));
        send_page(16'h7FFF);
        send_page(16'h7FFF);
    endtask

    // random phases: working sets around the ring size, some noise pages
    task automatic test_random_references(input int phases, input int per_phase);
        logic [PAGE_BITS-1:0] working_set[$];
        logic [CFG_W-1:0] size_cfg;
        int n;
        int ws;
        for (int p = 0; p < phases; p++) begin
            case (p % 8)
                0: size_cfg = CFG_W'(2);
                1: size_cfg = CFG_W'(1);
                2: size_cfg = CFG_W'(32);
                3: size_cfg = CFG_W'(5);
                4: size_cfg = CFG_W'($urandom_range(0, 63));
                6: size_cfg = CFG_W'(63);
                default: size_cfg = CFG_W'($urandom_range(1, 8));
            endcase
            write_frames_in_use(size_cfg);
            n = int'(size_cfg);
            if (n == 0) n = 1;
            if (n > FRAMES) n = FRAMES;
            ws = n + $urandom_range(0, n / 2 + 2);
            working_set.delete();
            for (int w = 0; w < ws; w++) begin
                working_set.insert(working_set.size(), PAGE_BITS'($urandom_range(0, 65535)));
            end
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(0, 4) == 0) send_page(PAGE_BITS'($urandom_range(0, 65535)));
                else send_page(working_set[$urandom_range(0, ws - 1)]);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        ring_cfg    = CFG_W'(FRAMES);
        ring_faults = '0;
        empty_ring();
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_ring();
        test_single_frame();
        test_second_chance();
        test_oversized_ring();
        test_random_references(8, 50);

        drain_results();
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[clock_page_replacement_unit] OK");
        end else begin
            $display("[clock_page_replacement_unit] ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("[clock_page_replacement_unit] ERROR");
        $finish;
    end

endmodule
